### rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/mtrdf_pkg.sv
package mtrdf_pkg;

  localparam int unsigned MAX_RULES = 256;

  localparam int unsigned TYPE_W = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned DIV_W  = 8;
  localparam int unsigned OP_W   = 2;

  // Rule count can hold MAX_RULES itself.
  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);

  // The rule cells are scanned one segment per cycle.
  localparam int unsigned SEG_CELLS = (MAX_RULES < 32) ? MAX_RULES : 32;
  localparam int unsigned NUM_SEGS  = (MAX_RULES + SEG_CELLS - 1) / SEG_CELLS;
  localparam int unsigned SEG_W     = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;

  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = LEN_W'(6);
  localparam logic [DIV_W-1:0] COUNTER_STEP    = DIV_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_JUDGE  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // Handed from one cell to the next during a scan.
  typedef struct packed {
    logic found;
    logic pass;
  } link_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic wr;
    logic act;
  } cell_ctrl_t;

endpackage

### rtl/mtrdf_if.sv
interface mtrdf_in_if import mtrdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [TYPE_W-1:0] type_id;
  logic [LEN_W-1:0]  frame_length;
  logic [DIV_W-1:0]  divisor;

  modport source (output valid, output opcode, output type_id, output frame_length,
                  output divisor, input ready);
  modport sink (input valid, input opcode, input type_id, input frame_length,
                input divisor, output ready);
endinterface

interface mtrdf_out_if;
  logic valid;
  logic ready;
  logic pass_message;
  logic rule_refused;

  modport source (output valid, output pass_message, output rule_refused, input ready);
  modport sink (input valid, input pass_message, input rule_refused, output ready);
endinterface

### rtl/message_type_rate_divider_filter_top.sv
// Message type rate divider filter.
// Input channel in_i carries one command beat: opcode (judge, append rule,
// clear rules), type_id, frame_length and divisor. Output channel out_o
// returns exactly one beat per command: pass_message and rule_refused.
// Appends and clears take effect at the input handshake. Every answer goes
// from the HOLD state into the output register, where it is valid; before
// that, a judge of a long enough message against a non-empty table scans
// the rule cells in the SCAN state, one segment of 32 per cycle, through all
// NUM_SEGS segments.
// The block takes one command at a time. A new command is accepted as soon
// as the previous one has reached the output register, even while that
// beat still waits for the receiver. When the receiver stalls with a beat
// held and another answer ready, the block waits and accepts nothing more.
// Reset empties the rule table and the output register; rule contents are
// not cleared and are only read below the rule count.
`include "assert_macros.svh"

module message_type_rate_divider_filter_top import mtrdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtrdf_in_if.sink    in_i,
  mtrdf_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SEG_W-1:0]   seg_q, seg_d;
  link_t              seg_link_q, seg_link_d;
  logic [TYPE_W-1:0]  key_q;
  logic               res_pass_q, res_pass_d;
  logic               res_ref_q, res_ref_d;
  logic               out_valid_q, out_valid_d;
  logic               out_pass_q, out_ref_q;

  logic               in_fire;
  logic               out_load;
  logic               full;
  logic               do_append;
  logic               last_seg;

  cell_ctrl_t         ctrl   [MAX_RULES];
  link_t              link_in [MAX_RULES];
  link_t              link_out[MAX_RULES];
  logic [MAX_RULES-1:0] hit_vec;
  link_t              seg_end[NUM_SEGS];

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign full      = (count_q == CNT_W'(MAX_RULES));
  assign do_append = in_fire && (in_i.opcode == OP_APPEND) && !full;
  assign last_seg  = (seg_q == SEG_W'(NUM_SEGS - 1));
  assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || out_o.ready);

  // Rule cells.
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    assign ctrl[i].wr  = do_append && (count_q == CNT_W'(i));
    assign ctrl[i].act = (state_q == ST_SCAN) && (seg_q == SEG_W'(i / SEG_CELLS))
                         && (CNT_W'(i) < count_q);

    if ((i % SEG_CELLS) == 0) begin : g_head
      assign link_in[i] = seg_link_q;
    end else begin : g_body
      assign link_in[i] = link_out[i-1];
    end

    mtrdf_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .wr_type_i (in_i.type_id),
      .wr_div_i  (in_i.divisor),
      .key_i     (key_q),
      .link_i    (link_in[i]),
      .link_o    (link_out[i]),
      .hit_o     (hit_vec[i])
    );
  end

  for (genvar s = 0; s < NUM_SEGS; s++) begin : g_seg
    localparam int unsigned LAST = ((s + 1) * SEG_CELLS > MAX_RULES)
                                   ? MAX_RULES - 1 : (s + 1) * SEG_CELLS - 1;
    assign seg_end[s] = link_out[LAST];
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    seg_d      = seg_q;
    seg_link_d = seg_link_q;
    res_pass_d = res_pass_q;
    res_ref_d  = res_ref_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_pass_d = 1'b0;
          res_ref_d  = 1'b0;
          state_d    = ST_HOLD;
          unique case (opcode_e'(in_i.opcode))
            OP_JUDGE: begin
              if (count_q == '0) begin
                res_pass_d = 1'b1;
              end else if (in_i.frame_length >= MIN_FRAME_BYTES) begin
                seg_d      = '0;
                seg_link_d = '0;
                state_d    = ST_SCAN;
              end
            end
            OP_APPEND: begin
              if (full) begin
                res_ref_d = 1'b1;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_CLEAR: count_d = '0;
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        seg_link_d = seg_end[seg_q];
        seg_d      = seg_q + SEG_W'(1);
        if (last_seg) begin
          res_pass_d = seg_end[seg_q].pass;
          state_d    = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q      <= seg_d;
    seg_link_q <= seg_link_d;
    res_pass_q <= res_pass_d;
    res_ref_q  <= res_ref_d;
    if (in_fire) begin
      key_q <= in_i.type_id;
    end
    if (out_load) begin
      out_pass_q <= res_pass_q;
      out_ref_q  <= res_ref_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pass_message = out_pass_q;
  assign out_o.rule_refused = out_ref_q;

  `ASSERT_STD(a_count_bound, count_q <= CNT_W'(MAX_RULES), "rule count beyond table size")
  `ASSERT_STD(a_single_hit, $onehot0(hit_vec), "more than one rule cell claimed a message")
  `ASSERT_STD(a_scan_nonempty, (state_q == ST_SCAN) |-> (count_q != '0), "scan on empty table")
  `ASSERT_STD(a_result_excl, out_o.valid |-> !(out_o.pass_message && out_o.rule_refused),
              "pass and refused both set")

endmodule

### rtl/mtrdf_cell.sv
module mtrdf_cell import mtrdf_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [TYPE_W-1:0] wr_type_i,
  input  logic [DIV_W-1:0]  wr_div_i,
  input  logic [TYPE_W-1:0] key_i,
  input  link_t             link_i,
  output link_t             link_o,
  output logic              hit_o
);

  logic [TYPE_W-1:0] type_q;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W-1:0]  cnt_q;
  logic [DIV_W-1:0]  cnt_inc;
  logic              reach;
  logic              hit;

  // Only the first matching cell of the chain claims the message.
  assign hit     = ctrl_i.act && !link_i.found && (type_q == key_i);
  assign cnt_inc = cnt_q + COUNTER_STEP;
  assign reach   = (cnt_inc >= div_q);

  assign link_o.found = link_i.found | hit;
  assign link_o.pass  = hit ? ((div_q != '0) && reach) : link_i.pass;
  assign hit_o        = hit;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      type_q <= wr_type_i;
      div_q  <= wr_div_i;
      cnt_q  <= '0;
    end else if (hit && (div_q != '0)) begin
      cnt_q <= reach ? '0 : cnt_inc;
    end
  end

endmodule

### tb/sv/message_type_rate_divider_filter_top_tb.sv
module message_type_rate_divider_filter_top_tb import mtrdf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    opcode_e           op;
    logic [TYPE_W-1:0] type_id;
    logic [LEN_W-1:0]  frame_length;
    logic [DIV_W-1:0]  divisor;
  } filter_cmd_t;

  typedef struct packed {
    logic fwd;
    logic refused;
  } verdict_t;

  logic clk;
  logic rst_n;

  mtrdf_in_if  in_if ();
  mtrdf_out_if out_if ();

  message_type_rate_divider_filter_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow copy of the rule table.
  logic [TYPE_W-1:0] shadow_type [MAX_RULES];
  logic [DIV_W-1:0]  shadow_div  [MAX_RULES];
  logic [DIV_W-1:0]  shadow_cnt  [MAX_RULES];
  int unsigned       shadow_total;

  verdict_t verdict_q[$];

  int error_count;
  int n_judged, n_forwarded, n_appends, n_refused, n_clears, n_other;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic verdict_t filter_predict(filter_cmd_t c);
    verdict_t         v;
    logic             found;
    logic [DIV_W-1:0] bumped;
    v = '0;
    found = 1'b0;
    case (c.op)
      OP_JUDGE: begin
        if (shadow_total == 0) begin
          v.fwd = 1'b1;
        end else if (c.frame_length >= MIN_FRAME_BYTES) begin
          for (int k = 0; k < shadow_total && !found; k++) begin
            if (shadow_type[k] == c.type_id) begin
              found = 1'b1;
              if (shadow_div[k] != '0) begin
                bumped = shadow_cnt[k] + COUNTER_STEP;
                if (bumped >= shadow_div[k]) begin
                  shadow_cnt[k] = '0;
                  v.fwd = 1'b1;
                end else begin
                  shadow_cnt[k] = bumped;
                end
              end
            end
          end
        end
      end
      OP_APPEND: begin
        if (shadow_total < MAX_RULES) begin
          shadow_type[shadow_total] = c.type_id;
          shadow_div[shadow_total]  = c.divisor;
          shadow_cnt[shadow_total]  = '0;
          shadow_total++;
        end else begin
          v.refused = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_total = 0;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Results are checked before the same edge's command is predicted; a result
  // can never belong to a command accepted at that very edge.
  always @(posedge clk) begin
    filter_cmd_t c;
    verdict_t    want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no command outstanding");
          error_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_if.pass_message !== want.fwd) begin
            $error("pass_message: expected %0b, actual %0b", want.fwd, out_if.pass_message);
            error_count++;
          end
          if (out_if.rule_refused !== want.refused) begin
            $error("rule_refused: expected %0b, actual %0b", want.refused,
                   out_if.rule_refused);
            error_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        c.op           = opcode_e'(in_if.opcode);
        c.type_id      = in_if.type_id;
        c.frame_length = in_if.frame_length;
        c.divisor      = in_if.divisor;
        want = filter_predict(c);
        verdict_q.push_back(want);
        case (c.op)
          OP_JUDGE: begin
            n_judged++;
            if (want.fwd) n_forwarded++;
          end
          OP_APPEND: begin
            n_appends++;
            if (want.refused) n_refused++;
          end
          OP_CLEAR: n_clears++;
          default:  n_other++;
        endcase
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_cmd(input opcode_e op, input logic [TYPE_W-1:0] type_id,
                          input logic [LEN_W-1:0] frame_length,
                          input logic [DIV_W-1:0] divisor);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid        <= 1'b0;
      in_if.opcode       <= OP_W'($urandom);
      in_if.type_id      <= TYPE_W'($urandom);
      in_if.frame_length <= LEN_W'($urandom);
      in_if.divisor      <= DIV_W'($urandom);
      @(posedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.type_id      <= type_id;
    in_if.frame_length <= frame_length;
    in_if.divisor      <= divisor;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] rand_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return LEN_W'($urandom_range(5));
    if (r < 20) return LEN_W'($urandom);
    return LEN_W'($urandom_range(1500, 6));
  endfunction

  function automatic logic [DIV_W-1:0] rand_divisor();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return DIV_W'($urandom);
    return DIV_W'($urandom_range(6, 1));
  endfunction

  task automatic test_directed();
    // Empty table forwards anything, even a zero-length message.
    send_cmd(OP_JUDGE, 16'hFFFF, 16'd0, 8'hFF);
    send_cmd(OP_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);
    // Zero divisor always drops.
    send_cmd(OP_APPEND, 16'h0000, 16'd0, 8'd0);
    send_cmd(OP_JUDGE, 16'h0000, 16'd100, 8'd0);
    // Divisor one forwards every message long enough; length 6 is the boundary.
    send_cmd(OP_APPEND, 16'hFFFF, 16'hFFFF, 8'd1);
    send_cmd(OP_JUDGE, 16'hFFFF, 16'd6, 8'd0);
    send_cmd(OP_JUDGE, 16'hFFFF, 16'd5, 8'd0);
    send_cmd(OP_JUDGE, 16'hFFFF, 16'hFFFF, 8'd0);
    // One in three, then a duplicate rule that must never be reached.
    send_cmd(OP_APPEND, 16'h1234, 16'd0, 8'd3);
    send_cmd(OP_JUDGE, 16'h1234, 16'd8, 8'd0);
    send_cmd(OP_JUDGE, 16'h1234, 16'd8, 8'd0);
    send_cmd(OP_APPEND, 16'h1234, 16'd0, 8'd1);
    send_cmd(OP_JUDGE, 16'h1234, 16'd8, 8'd0);
    send_cmd(OP_JUDGE, 16'h1234, 16'd8, 8'd0);
    // No matching rule.
    send_cmd(OP_JUDGE, 16'hABCD, 16'd64, 8'd0);
    send_cmd(OP_APPEND, 16'hAAAA, 16'd0, 8'hFF);
    send_cmd(OP_JUDGE, 16'hAAAA, 16'd64, 8'd0);
    // After a clear the table is empty again, so short messages pass.
    send_cmd(OP_CLEAR, 16'h5555, 16'h5555, 8'h55);
    send_cmd(OP_JUDGE, 16'h1234, 16'd3, 8'd0);
    send_cmd(OP_JUDGE, 16'h0000, 16'd0, 8'd0);
  endtask

  task automatic test_full_table();
    send_cmd(OP_CLEAR, '0, '0, '0);
    for (int k = 0; k < MAX_RULES; k++) begin
      send_cmd(OP_APPEND, TYPE_W'(16'h8000 | k), LEN_W'($urandom),
               DIV_W'($urandom_range(3, 1)));
    end
    send_cmd(OP_APPEND, 16'h7777, 16'd0, 8'd1);
    send_cmd(OP_APPEND, 16'h8000, 16'd0, 8'd1);
    for (int k = 0; k < 12; k++) begin
      send_cmd(OP_JUDGE, 16'h8000, 16'd20, 8'd0);
      send_cmd(OP_JUDGE, TYPE_W'(16'h8000 | (MAX_RULES - 1)), 16'd20, 8'd0);
      send_cmd(OP_JUDGE, 16'h7777, 16'd20, 8'd0);
    end
    send_cmd(OP_CLEAR, '0, '0, '0);
  endtask

  // Phases of: maybe a clear, a batch of rules drawn from a small type pool,
  // then a burst of messages mostly of those types so that rules really match.
  task automatic test_random_traffic(input int n_items);
    logic [TYPE_W-1:0] pool [8];
    int                sent;
    int                pick;
    int                n_rules;
    int                n_msgs;
    logic [TYPE_W-1:0] t;
    sent = 0;
    while (sent < n_items) begin
      foreach (pool[i]) pool[i] = TYPE_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_cmd(OP_CLEAR, TYPE_W'($urandom), LEN_W'($urandom), DIV_W'($urandom));
        sent++;
      end
      n_rules = (pick >= 97) ? $urandom_range(MAX_RULES + 4, MAX_RULES - 16)
                             : $urandom_range(8, 0);
      for (int k = 0; k < n_rules; k++) begin
        t = ($urandom_range(9) == 0) ? TYPE_W'($urandom) : pool[$urandom_range(5)];
        send_cmd(OP_APPEND, t, LEN_W'($urandom), rand_divisor());
        sent++;
      end
      n_msgs = $urandom_range(60, 10);
      for (int k = 0; k < n_msgs; k++) begin
        if ($urandom_range(99) < 3) begin
          send_cmd(OP_NONE, TYPE_W'($urandom), LEN_W'($urandom), DIV_W'($urandom));
        end else begin
          t = ($urandom_range(9) < 8) ? pool[$urandom_range(7)] : TYPE_W'($urandom);
          send_cmd(OP_JUDGE, t, rand_length(), DIV_W'($urandom));
        end
        sent++;
      end
    end
  endtask

  task automatic test_no_gaps();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);
    send_idle_pct = 27;
    recv_idle_pct = 27;
  endtask

  // The receiver holds off long enough for the block to fill and refuse input.
  task automatic test_output_stall();
    hold_len = 400;
    hold_reqs++;
    send_cmd(OP_APPEND, 16'h0042, 16'd0, 8'd2);
    for (int k = 0; k < 30; k++) begin
      send_cmd(OP_JUDGE, ($urandom_range(1) != 0) ? 16'h0042 : TYPE_W'($urandom),
               rand_length(), '0);
    end
  endtask

  initial begin
    error_count   = 0;
    n_judged      = 0;
    n_forwarded   = 0;
    n_appends     = 0;
    n_refused     = 0;
    n_clears      = 0;
    n_other       = 0;
    shadow_total  = 0;
    send_idle_pct = 27;
    recv_idle_pct = 27;
    hold_reqs     = 0;
    hold_len      = 0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = '0;
    in_if.type_id      = '0;
    in_if.frame_length = '0;
    in_if.divisor      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_table();
    test_output_stall();
    test_random_traffic(600);
    test_no_gaps();
    test_random_traffic(500);
    stop_sending();

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (NUM_SEGS + 8) @(posedge clk);

    $display("Covered %0d judged messages (%0d forwarded), %0d rule appends (%0d refused),",
             n_judged, n_forwarded, n_appends, n_refused);
    $display("%0d table clears and %0d unused opcodes, under random stalls on both sides.",
             n_clears, n_other);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mtrdf_pkg.sv
rtl/mtrdf_if.sv
rtl/mtrdf_cell.sv
rtl/message_type_rate_divider_filter_top.sv
tb/sv/message_type_rate_divider_filter_top_tb.sv
